/* rtl/core/text_console_glyph_renderer_defines.svh */
// Assertion macros shared by the text console RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TCGR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TCGR_ASSERT(lbl, prop, msg)
`define TCGR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/core/tcgr_pkg.sv */
// Shared types and constants of the text console glyph renderer.
// No dependencies.
`timescale 1ns / 1ps
package tcgr_pkg;
	localparam int COORD_W     = 12;
	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 4096;
	localparam int COLOR_W     = 32;
	localparam int GLYPH_WIDTH = 8;
	localparam int QUEUE_DEPTH = 2;   // power of two

	// copy height is kept to whole 16-pixel rows
	localparam logic [COORD_W-1:0] SPAN_MASK = 12'hff0;

	localparam logic       KIND_LOAD    = 1'b0;
	localparam logic       KIND_CHAR    = 1'b1;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
	localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd768;
	localparam logic [COLOR_W-1:0] RST_TEXT_COLOR    = 32'h00ff_ffff;
	localparam logic [COLOR_W-1:0] RST_BG_COLOR      = 32'h0000_0000;

	typedef enum logic [1:0] {
		OP_BLIT = 2'd0,
		OP_COPY = 2'd1,
		OP_FILL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_TEXT_COLOR    = 2'd2,
		CFG_BG_COLOR      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] screen_width;
		logic [COORD_W-1:0] screen_height;
		logic [COLOR_W-1:0] text_color;
		logic [COLOR_W-1:0] background_color;
	} cfg_t;

	// one queued job: a store write, or glyph rows and/or a scroll
	typedef struct packed {
		logic               write;
		logic               blit;
		logic               scroll;
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         data;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} job_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [COORD_W-1:0] area_width;
		logic [COORD_W-1:0] area_height;
		logic [COORD_W-1:0] source_y;
		logic [COLOR_W-1:0] fill_color;
		logic [3:0][63:0]   pixels;
		logic               last;
	} res_t;
endpackage

/* rtl/core/tcgr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/tcgr_front.sv */
// Front end: takes input words, keeps the cursor and turns each word but a plain newline into a job.
// Uses tcgr_pkg.
`timescale 1ns / 1ps
module tcgr_front import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               kind,
	input  logic [ADDR_W-1:0]  glyph_address,
	input  logic [7:0]         glyph_byte,
	input  logic [7:0]         char_code,
	input  cfg_t               cfg,
	output logic               push,
	output job_t               job
);
	localparam logic [COORD_W-1:0] GH12 = COORD_W'(GLYPH_HEIGHT);
	localparam logic [COORD_W:0]   GH2  = (COORD_W+1)'(2 * GLYPH_HEIGHT);
	localparam logic [COORD_W:0]   GW2  = (COORD_W+1)'(2 * GLYPH_WIDTH);
	localparam logic [COORD_W-1:0] GW12 = COORD_W'(GLYPH_WIDTH);

	logic [COORD_W-1:0] col_q, row_q;
	logic [COORD_W-1:0] col_n, row_n;
	logic [COORD_W:0]   row_reach, col_reach;
	logic               is_nl, scroll;
	logic [ADDR_W-1:0]  glyph_base;

	assign is_nl      = (char_code == CHAR_NEWLINE);
	assign row_reach  = {1'b0, row_q} + GH2;
	assign col_reach  = {1'b0, col_q} + GW2;
	assign glyph_base = ADDR_W'({4'b0, char_code} * GH12);

	always_comb begin
		col_n  = col_q;
		row_n  = row_q;
		scroll = 1'b0;
		if (kind == KIND_CHAR) begin
			if (is_nl) begin
				col_n = '0;
				if (row_reach > {1'b0, cfg.screen_height}) begin
					scroll = 1'b1;
				end else begin
					row_n = row_q + GH12;
				end
			end else if (col_reach > {1'b0, cfg.screen_width}) begin
				col_n = '0;
				// wrap at the bottom scrolls one line earlier than a newline
				if (row_reach >= {1'b0, cfg.screen_height}) begin
					scroll = 1'b1;
				end else begin
					row_n = row_q + GH12;
				end
			end else begin
				col_n = col_q + GW12;
			end
		end
	end

	always_comb begin
		job.write  = (kind == KIND_LOAD);
		job.blit   = (kind == KIND_CHAR) && !is_nl;
		job.scroll = scroll;
		job.addr   = (kind == KIND_LOAD) ? glyph_address : glyph_base;
		job.data   = glyph_byte;
		job.x      = col_q;
		job.y      = row_q;
	end

	// a plain newline only moves the cursor
	assign push = accept && (job.write || job.blit || job.scroll);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end
endmodule

/* rtl/core/tcgr_queue.sv */
// Short job queue between front end and back end.
// Uses tcgr_pkg.
`timescale 1ns / 1ps
module tcgr_queue import tcgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	input  logic pop,
	output job_t job_out,
	output logic empty,
	output logic full
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_FULL);
	assign job_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

/* rtl/core/tcgr_back.sv */
// Back end: glyph store, row sequencer and the registered command outputs.
// Uses tcgr_pkg, tcgr_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "text_console_glyph_renderer_defines.svh"
module tcgr_back import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t job,
	input  logic job_valid,
	output logic pop,
	output logic strobe,
	output res_t res
);
	localparam int ROW_W = $clog2(GLYPH_HEIGHT);
	localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(GLYPH_HEIGHT - 1);
	localparam logic [COORD_W-1:0] GH12     = COORD_W'(GLYPH_HEIGHT);
	localparam logic [COORD_W-1:0] GW12     = COORD_W'(GLYPH_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROWS,
		ST_DRAIN,
		ST_COPY,
		ST_FILL
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [ROW_W-1:0]   row_q;
	logic               rd_s1, rd_last_s1;
	logic [COORD_W-1:0] rd_y_s1;
	logic               strobe_q;
	res_t               res_q;

	logic [ADDR_W-1:0]  raddr;
	logic [7:0]         rdata;
	logic [COORD_W-1:0] span;
	logic [7:0][31:0]   px_color;
	logic [3:0][63:0]   px_pair;

	assign pop   = job_valid && (state_q == ST_IDLE);
	assign raddr = job_q.addr + ADDR_W'(row_q);

	tcgr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (pop && job.write),
		.waddr (job.addr),
		.wdata (job.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (cfg.screen_height >= GH12) begin
			span = (cfg.screen_height - GH12) & SPAN_MASK;
		end else begin
			span = '0;
		end
	end

	// msb of the glyph byte is pixel 0
	always_comb begin
		for (int p = 0; p < 8; p++) begin
			px_color[p] = rdata[7-p] ? cfg.text_color : cfg.background_color;
		end
		for (int j = 0; j < 4; j++) begin
			px_pair[j] = {px_color[2*j+1], px_color[2*j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			job_q      <= '0;
			row_q      <= '0;
			rd_s1      <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_y_s1    <= '0;
			strobe_q   <= 1'b0;
			res_q      <= '0;
		end else begin
			strobe_q <= rd_s1 || (state_q == ST_COPY) || (state_q == ST_FILL);
			rd_s1    <= (state_q == ST_ROWS);

			// read data of the previous row is in; emit its blit
			if (rd_s1) begin
				res_q.op          <= OP_BLIT;
				res_q.dest_x      <= job_q.x;
				res_q.dest_y      <= rd_y_s1;
				res_q.area_width  <= GW12;
				res_q.area_height <= COORD_W'(1);
				res_q.source_y    <= '0;
				res_q.fill_color  <= '0;
				res_q.pixels      <= px_pair;
				res_q.last        <= rd_last_s1;
			end

			case (state_q)
				ST_IDLE: begin
					if (pop && !job.write) begin
						job_q   <= job;
						row_q   <= '0;
						state_q <= job.blit ? ST_ROWS : ST_COPY;
					end
				end
				ST_ROWS: begin
					rd_y_s1    <= job_q.y + COORD_W'(row_q);
					rd_last_s1 <= (row_q == ROW_LAST) && !job_q.scroll;
					if (row_q == ROW_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= job_q.scroll ? ST_COPY : ST_IDLE;
				end
				ST_COPY: begin
					res_q.op          <= OP_COPY;
					res_q.dest_x      <= '0;
					res_q.dest_y      <= '0;
					res_q.area_width  <= cfg.screen_width;
					res_q.area_height <= span;
					res_q.source_y    <= GH12;
					res_q.fill_color  <= '0;
					res_q.pixels      <= '0;
					res_q.last        <= 1'b0;
					state_q           <= ST_FILL;
				end
				ST_FILL: begin
					res_q.op          <= OP_FILL;
					res_q.dest_x      <= '0;
					res_q.dest_y      <= span;
					res_q.area_width  <= cfg.screen_width;
					res_q.area_height <= GH12;
					res_q.source_y    <= '0;
					res_q.fill_color  <= '0;
					res_q.pixels      <= '0;
					res_q.last        <= 1'b1;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

	`TCGR_ASSERT(a_last_then_gap, strobe_q && res_q.last |=> !strobe_q, "word after last")
	`TCGR_ASSERT(a_rows_in_order, strobe_q && res_q.op == OP_BLIT && !res_q.last |=> strobe_q && ((res_q.op == OP_BLIT && res_q.dest_y == COORD_W'($past(res_q.dest_y) + 12'd1)) || res_q.op == OP_COPY), "glyph rows out of order")
	`TCGR_ASSERT(a_copy_then_fill, strobe_q && res_q.op == OP_COPY |=> strobe_q && res_q.op == OP_FILL && res_q.last, "copy without fill")
	`TCGR_ASSERT_NEVER(a_blit_vs_scroll, rd_s1 && (state_q == ST_COPY || state_q == ST_FILL), "blit collides with scroll")
endmodule

/* rtl/core/text_console_glyph_renderer.sv */
// Top level of the text console glyph renderer: config registers and the three parts.
// Uses tcgr_pkg, tcgr_front, tcgr_queue, tcgr_back.
//
//  channel   handshake                 words
//  input     start && !busy            kind, glyph_address, glyph_byte, char_code
//  config    cfg_valid && cfg_ready    cfg_index, cfg_data
//  result    strobe, one cycle         op .. pixels_67, last
//
// In the back end a character takes one glyph store read per row (registered read),
// then a drain step, and a scroll adds a copy and a fill word; a font load is a
// single store write. The row sequencer sets the rate; the front end keeps accepting
// until the two-entry job queue is full. Reset clears cursor, queue and sequencer;
// the glyph store is not cleared. Results cannot be held off.
`timescale 1ns / 1ps
module text_console_glyph_renderer import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [ADDR_W-1:0]  glyph_address,
	input  logic [7:0]         glyph_byte,
	input  logic [7:0]         char_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [COLOR_W-1:0] cfg_data,
	output logic               strobe,
	output logic [1:0]         op,
	output logic [COORD_W-1:0] dest_x,
	output logic [COORD_W-1:0] dest_y,
	output logic [COORD_W-1:0] area_width,
	output logic [COORD_W-1:0] area_height,
	output logic [COORD_W-1:0] source_y,
	output logic [COLOR_W-1:0] fill_color,
	output logic [63:0]        pixels_01,
	output logic [63:0]        pixels_23,
	output logic [63:0]        pixels_45,
	output logic [63:0]        pixels_67,
	output logic               last
);
	cfg_t cfg_q;
	logic accept, push, pop, q_empty, q_full;
	job_t job_in, job_out;
	res_t res;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width     <= RST_SCREEN_WIDTH;
			cfg_q.screen_height    <= RST_SCREEN_HEIGHT;
			cfg_q.text_color       <= RST_TEXT_COLOR;
			cfg_q.background_color <= RST_BG_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_WIDTH:  cfg_q.screen_width     <= cfg_data[COORD_W-1:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height    <= cfg_data[COORD_W-1:0];
				CFG_TEXT_COLOR:    cfg_q.text_color       <= cfg_data;
				CFG_BG_COLOR:      cfg_q.background_color <= cfg_data;
				default:           cfg_q                  <= cfg_q;
			endcase
		end
	end

	tcgr_front #(
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.kind          (kind),
		.glyph_address (glyph_address),
		.glyph_byte    (glyph_byte),
		.char_code     (char_code),
		.cfg           (cfg_q),
		.push          (push),
		.job           (job_in)
	);

	tcgr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.empty   (q_empty),
		.full    (q_full)
	);

	tcgr_back #(
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (job_out),
		.job_valid (!q_empty),
		.pop       (pop),
		.strobe    (strobe),
		.res       (res)
	);

	assign op          = res.op;
	assign dest_x      = res.dest_x;
	assign dest_y      = res.dest_y;
	assign area_width  = res.area_width;
	assign area_height = res.area_height;
	assign source_y    = res.source_y;
	assign fill_color  = res.fill_color;
	assign pixels_01   = res.pixels[0];
	assign pixels_23   = res.pixels[1];
	assign pixels_45   = res.pixels[2];
	assign pixels_67   = res.pixels[3];
	assign last        = res.last;
endmodule
